// File: rtl/core/blae_pkg.sv
// ----------------------------------------------------------------------------
// blae_pkg
// Shared types, command codes and defaults for the binary lifting ancestor
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package blae_pkg;

    // field widths of the request and response words, and the depth width
    localparam int CMD_W   = 2;
    localparam int NODE_W  = 10;
    localparam int DIST_W  = 10;
    localparam int DEPTH_W = 10;

    // default table geometry
    localparam int unsigned MAX_NODES_DEF = 1024;
    localparam int unsigned LEVELS_DEF    = 11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LCA = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KTH = 2'd2;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_DRD,
        ST_ADD_W0,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_DWR,
        ST_LCA_DA,
        ST_LCA_DB,
        ST_LCA_CMP,
        ST_CLIMB,
        ST_CLIMB_WT,
        ST_CLIMB_END,
        ST_JOINT_RA,
        ST_JOINT_RB,
        ST_JOINT_CMP,
        ST_FINAL_RD,
        ST_FINAL_WT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/blae_req_if.sv
// ----------------------------------------------------------------------------
// blae_req_if
// Request channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface blae_req_if;

    logic                          valid;
    logic                          ready;
    logic [blae_pkg::CMD_W-1:0]    command;
    logic [blae_pkg::NODE_W-1:0]   node_id;
    logic [blae_pkg::NODE_W-1:0]   other_node;
    logic                          has_parent;
    logic [blae_pkg::DIST_W-1:0]   distance;

    modport source (
        output valid, command, node_id, other_node, has_parent, distance,
        input  ready
    );

    modport sink (
        input  valid, command, node_id, other_node, has_parent, distance,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/blae_rsp_if.sv
// ----------------------------------------------------------------------------
// blae_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface blae_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [blae_pkg::NODE_W-1:0]   result_node;
    logic                          result_valid;

    modport source (
        output valid, result_node, result_valid,
        input  ready
    );

    modport sink (
        input  valid, result_node, result_valid,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/binary_lifting_ancestor_engine_top.sv
// One word at a time: a new word is taken only in the idle state, after an add has
// written its rows or a query result has been handed to the output register, where it
// may wait. The single-port ancestor memory does one access per cycle and sets the
// pace.
// Reset clears the sequencer and output valid only; tables are not cleared.
// ----------------------------------------------------------------------------
// binary_lifting_ancestor_engine_top
// Jump table of 2^i-th ancestors per node plus depth table; answers kth
// ancestor and lowest common ancestor queries by binary lifting.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_lifting_ancestor_engine_top #(
    parameter int unsigned MAX_NODES = blae_pkg::MAX_NODES_DEF,
    parameter int unsigned LEVELS    = blae_pkg::LEVELS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    blae_req_if.sink    req,
    blae_rsp_if.source  rsp
);

    // node index, entry code (node+1, zero means none) and level widths
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int AW = NW + LW;
    localparam int DW = blae_pkg::DEPTH_W;
    localparam int unsigned DepthCap = (MAX_NODES - 1 < 1023) ? MAX_NODES - 1 : 1023;

    localparam logic [LW-1:0] LvlTop = LW'(LEVELS - 1);
    localparam logic [CW-1:0] CodeOne = CW'(1);

    // tables
    logic [CW-1:0] anc_mem [2**AW];
    logic [DW-1:0] dep_mem [2**NW];

    // sequencer and datapath registers
    blae_pkg::state_t state_reg, state_next;
    logic [blae_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [NW-1:0]     par_reg, par_next;
    logic              hp_reg, hp_next;
    logic [LEVELS-1:0] k_reg, k_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [CW-1:0]     ca_reg, ca_next;
    logic [CW-1:0]     cb_reg, cb_next;
    logic [CW-1:0]     ua_reg, ua_next;
    logic [DW-1:0]     da_reg, da_next;
    logic [DW-1:0]     dnew_reg, dnew_next;
    logic [CW-1:0]     res_reg, res_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [blae_pkg::NODE_W-1:0] out_node_reg, out_node_next;
    logic              out_found_reg, out_found_next;

    // memory ports
    logic          anc_we;
    logic [AW-1:0] anc_addr;
    logic [CW-1:0] anc_wdata;
    logic [CW-1:0] anc_rd_reg;
    logic          dep_we;
    logic [NW-1:0] dep_addr;
    logic [DW-1:0] dep_wdata;
    logic [DW-1:0] dep_rd_reg;

    // shared conditions
    logic accept;
    logic node_ok;
    logic other_ok;
    logic ca_zero;
    logic lvl_zero;
    logic lvl_last;
    logic pair_differ;
    logic pair_broken;
    logic out_free;
    logic [DW:0] dep_inc;

    function automatic logic [NW-1:0] code_to_node(input logic [CW-1:0] code);
        logic [CW-1:0] tmp;
        tmp = code - CodeOne;
        return NW'(tmp);
    endfunction

    assign accept      = req.valid && req.ready;
    assign node_ok     = 32'(req.node_id) < MAX_NODES;
    assign other_ok    = 32'(req.other_node) < MAX_NODES;
    assign ca_zero     = (ca_reg == '0);
    assign lvl_zero    = (lvl_reg == '0);
    assign lvl_last    = (lvl_reg == LvlTop);
    assign pair_differ = (ua_reg != anc_rd_reg);
    assign pair_broken = (ua_reg == '0) || (anc_rd_reg == '0);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign dep_inc     = {1'b0, dep_rd_reg} + (DW+1)'(1);

    assign req.ready        = (state_reg == blae_pkg::ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_node  = out_node_reg;
    assign rsp.result_valid = out_found_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blae_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.command)
                        blae_pkg::CMD_ADD:
                        begin
                            if (node_ok && (!req.has_parent || other_ok))
                                state_next = blae_pkg::ST_ADD_DRD;
                        end
                        blae_pkg::CMD_LCA:
                            state_next = (node_ok && other_ok) ? blae_pkg::ST_LCA_DA
                                                               : blae_pkg::ST_FINISH;
                        blae_pkg::CMD_KTH:
                            state_next = node_ok ? blae_pkg::ST_CLIMB : blae_pkg::ST_FINISH;
                        default:
                            state_next = blae_pkg::ST_IDLE;
                    endcase
                end
            end
            blae_pkg::ST_ADD_DRD:   state_next = blae_pkg::ST_ADD_W0;
            blae_pkg::ST_ADD_W0:    state_next = blae_pkg::ST_ADD_RD;
            blae_pkg::ST_ADD_RD:
            begin
                if (!ca_zero)
                    state_next = blae_pkg::ST_ADD_WR;
                else if (lvl_last)
                    state_next = blae_pkg::ST_ADD_DWR;
            end
            blae_pkg::ST_ADD_WR:
                state_next = lvl_last ? blae_pkg::ST_ADD_DWR : blae_pkg::ST_ADD_RD;
            blae_pkg::ST_ADD_DWR:   state_next = blae_pkg::ST_IDLE;
            blae_pkg::ST_LCA_DA:    state_next = blae_pkg::ST_LCA_DB;
            blae_pkg::ST_LCA_DB:    state_next = blae_pkg::ST_LCA_CMP;
            blae_pkg::ST_LCA_CMP:   state_next = blae_pkg::ST_CLIMB;
            blae_pkg::ST_CLIMB:
            begin
                if (ca_zero)
                    state_next = blae_pkg::ST_CLIMB_END;
                else if (k_reg[lvl_reg])
                    state_next = blae_pkg::ST_CLIMB_WT;
                else if (lvl_zero)
                    state_next = blae_pkg::ST_CLIMB_END;
            end
            blae_pkg::ST_CLIMB_WT:
                state_next = lvl_zero ? blae_pkg::ST_CLIMB_END : blae_pkg::ST_CLIMB;
            blae_pkg::ST_CLIMB_END:
            begin
                if (cmd_reg == blae_pkg::CMD_KTH || ca_zero || ca_reg == cb_reg)
                    state_next = blae_pkg::ST_FINISH;
                else
                    state_next = blae_pkg::ST_JOINT_RA;
            end
            blae_pkg::ST_JOINT_RA:  state_next = blae_pkg::ST_JOINT_RB;
            blae_pkg::ST_JOINT_RB:  state_next = blae_pkg::ST_JOINT_CMP;
            blae_pkg::ST_JOINT_CMP:
            begin
                if (pair_differ && pair_broken)
                    state_next = blae_pkg::ST_FINISH;
                else if (lvl_zero)
                    state_next = blae_pkg::ST_FINAL_RD;
                else
                    state_next = blae_pkg::ST_JOINT_RA;
            end
            blae_pkg::ST_FINAL_RD:  state_next = blae_pkg::ST_FINAL_WT;
            blae_pkg::ST_FINAL_WT:  state_next = blae_pkg::ST_FINISH;
            blae_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = blae_pkg::ST_IDLE;
            end
            default:                state_next = blae_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory controls and output word
    always_comb
    begin
        cmd_next       = cmd_reg;
        node_next      = node_reg;
        par_next       = par_reg;
        hp_next        = hp_reg;
        k_next         = k_reg;
        lvl_next       = lvl_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        ua_next        = ua_reg;
        da_next        = da_reg;
        dnew_next      = dnew_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_node_next  = out_node_reg;
        out_found_next = out_found_reg;
        anc_we         = 1'b0;
        anc_addr       = '0;
        anc_wdata      = '0;
        dep_we         = 1'b0;
        dep_addr       = '0;
        dep_wdata      = '0;

        case (state_reg)
            blae_pkg::ST_IDLE:
            begin
                // latch the command word
                if (accept)
                begin
                    cmd_next  = req.command;
                    node_next = NW'(req.node_id);
                    par_next  = NW'(req.other_node);
                    hp_next   = req.has_parent;
                    k_next    = LEVELS'(req.distance);
                    lvl_next  = LvlTop;
                    ca_next   = CW'(req.node_id) + CodeOne;
                    res_next  = '0;
                end
            end
            blae_pkg::ST_ADD_DRD:
            begin
                dep_addr = par_reg;
            end
            blae_pkg::ST_ADD_W0:
            begin
                // level zero entry is the parent itself
                if (!hp_reg)
                    dnew_next = '0;
                else if (dep_inc > (DW+1)'(DepthCap))
                    dnew_next = DW'(DepthCap);
                else
                    dnew_next = DW'(dep_inc);
                anc_we    = 1'b1;
                anc_addr  = {node_reg, LW'(0)};
                anc_wdata = hp_reg ? ({1'b0, par_reg} + CW'(1)) : '0;
                ca_next   = anc_wdata;
                lvl_next  = LW'(1);
            end
            blae_pkg::ST_ADD_RD:
            begin
                if (ca_zero)
                begin
                    anc_we    = 1'b1;
                    anc_addr  = {node_reg, lvl_reg};
                    anc_wdata = '0;
                    if (!lvl_last)
                        lvl_next = lvl_reg + LW'(1);
                end
                else
                begin
                    anc_addr = {code_to_node(ca_reg), lvl_reg - LW'(1)};
                end
            end
            blae_pkg::ST_ADD_WR:
            begin
                anc_we    = 1'b1;
                anc_addr  = {node_reg, lvl_reg};
                anc_wdata = anc_rd_reg;
                ca_next   = anc_rd_reg;
                if (!lvl_last)
                    lvl_next = lvl_reg + LW'(1);
            end
            blae_pkg::ST_ADD_DWR:
            begin
                dep_we    = 1'b1;
                dep_addr  = node_reg;
                dep_wdata = dnew_reg;
            end
            blae_pkg::ST_LCA_DA:
            begin
                dep_addr = node_reg;
            end
            blae_pkg::ST_LCA_DB:
            begin
                da_next  = dep_rd_reg;
                dep_addr = par_reg;
            end
            blae_pkg::ST_LCA_CMP:
            begin
                // deeper node climbs by the depth difference
                lvl_next = LvlTop;
                if (da_reg < dep_rd_reg)
                begin
                    ca_next = {1'b0, par_reg} + CW'(1);
                    cb_next = {1'b0, node_reg} + CW'(1);
                    k_next  = LEVELS'(dep_rd_reg - da_reg);
                end
                else
                begin
                    ca_next = {1'b0, node_reg} + CW'(1);
                    cb_next = {1'b0, par_reg} + CW'(1);
                    k_next  = LEVELS'(da_reg - dep_rd_reg);
                end
            end
            blae_pkg::ST_CLIMB:
            begin
                if (!ca_zero)
                begin
                    if (k_reg[lvl_reg])
                        anc_addr = {code_to_node(ca_reg), lvl_reg};
                    else if (!lvl_zero)
                        lvl_next = lvl_reg - LW'(1);
                end
            end
            blae_pkg::ST_CLIMB_WT:
            begin
                ca_next = anc_rd_reg;
                if (!lvl_zero)
                    lvl_next = lvl_reg - LW'(1);
            end
            blae_pkg::ST_CLIMB_END:
            begin
                res_next = ca_reg;
                lvl_next = LvlTop;
            end
            blae_pkg::ST_JOINT_RA:
            begin
                anc_addr = {code_to_node(ca_reg), lvl_reg};
            end
            blae_pkg::ST_JOINT_RB:
            begin
                ua_next  = anc_rd_reg;
                anc_addr = {code_to_node(cb_reg), lvl_reg};
            end
            blae_pkg::ST_JOINT_CMP:
            begin
                // jump both while their ancestors differ
                if (pair_differ)
                begin
                    if (pair_broken)
                        res_next = '0;
                    else
                    begin
                        ca_next = ua_reg;
                        cb_next = anc_rd_reg;
                    end
                end
                if (!lvl_zero)
                    lvl_next = lvl_reg - LW'(1);
            end
            blae_pkg::ST_FINAL_RD:
            begin
                anc_addr = {code_to_node(ca_reg), LW'(0)};
            end
            blae_pkg::ST_FINAL_WT:
            begin
                res_next = anc_rd_reg;
            end
            blae_pkg::ST_FINISH:
            begin
                // hand the result to the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = (res_reg != '0);
                    out_node_next  = (res_reg == '0) ? '0
                                   : blae_pkg::NODE_W'(res_reg - CodeOne);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blae_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        node_reg      <= node_next;
        par_reg       <= par_next;
        hp_reg        <= hp_next;
        k_reg         <= k_next;
        lvl_reg       <= lvl_next;
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        ua_reg        <= ua_next;
        da_reg        <= da_next;
        dnew_reg      <= dnew_next;
        res_reg       <= res_next;
        out_node_reg  <= out_node_next;
        out_found_reg <= out_found_next;
    end

    // ancestor table, single port with registered read
    always_ff @(posedge clk)
    begin
        if (anc_we)
            anc_mem[anc_addr] <= anc_wdata;
        anc_rd_reg <= anc_mem[anc_addr];
    end

    // depth table, single port with registered read
    always_ff @(posedge clk)
    begin
        if (dep_we)
            dep_mem[dep_addr] <= dep_wdata;
        dep_rd_reg <= dep_mem[dep_addr];
    end

endmodule

`default_nettype wire

// File: verif/binary_lifting_ancestor_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_lifting_ancestor_engine_top_test
// Self-checking bench for the ancestor engine. Builds forests and one very
// deep chain through the request channel, mirrors every accepted add in its
// own jump and depth tables, and checks each lca and kth-ancestor answer
// against the mirror, with random idling on both channels and one long
// output hold-off.
// ----------------------------------------------------------------------------

module binary_lifting_ancestor_engine_top_test;

    localparam int NODES     = blae_pkg::MAX_NODES_DEF;
    localparam int LEVELS    = blae_pkg::LEVELS_DEF;
    localparam int DEPTH_CAP = (NODES - 1) < 1023 ? (NODES - 1) : 1023;

    // command code the block ignores
    localparam logic [blae_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [blae_pkg::CMD_W-1:0]  command;
        logic [blae_pkg::NODE_W-1:0] node_id;
        logic [blae_pkg::NODE_W-1:0] other_node;
        logic                        has_parent;
        logic [blae_pkg::DIST_W-1:0] distance;
    } req_word_t;

    typedef struct packed {
        logic [blae_pkg::NODE_W-1:0] node;
        logic                        found;
    } answer_t;

    logic clk;
    logic rst_n;

    blae_req_if req ();
    blae_rsp_if rsp ();

    binary_lifting_ancestor_engine_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // mirror of the jump rows (node+1, zero for none) and depths
    bit [blae_pkg::NODE_W:0]    lift_tbl [0:NODES-1][0:LEVELS-1];
    bit [blae_pkg::DEPTH_W-1:0] depth_tbl [0:NODES-1];

    req_word_t words_to_send [$];
    answer_t   answers_due [$];

    // generator bookkeeping: nodes that have a written row
    bit        added [0:NODES-1];
    int        known [$];

    int        cycle_count = 0;
    int        mismatches  = 0;
    bit        req_fired   = 1'b0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;
    logic      quiet;

    // no idling on either side in this window
    assign quiet = (cycle_count >= 20000) && (cycle_count < 30000);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // climb k generations from an entry code by the set bits of k
    function automatic bit [blae_pkg::NODE_W:0] climb_up(bit [blae_pkg::NODE_W:0] code,
                                                         int unsigned k);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (code != 0 && ((k >> i) & 1))
                code = lift_tbl[int'(code) - 1][i];
        end
        return code;
    endfunction

    // lift the deeper node, then jump both while their ancestors differ
    function automatic bit [blae_pkg::NODE_W:0] common_ancestor(int a, int b);
        bit [blae_pkg::NODE_W:0] ca;
        bit [blae_pkg::NODE_W:0] cb;
        bit [blae_pkg::NODE_W:0] ua;
        bit [blae_pkg::NODE_W:0] ub;
        int            da;
        int            db;
        int            t;
        da = depth_tbl[a];
        db = depth_tbl[b];
        if (da < db)
        begin
            t  = a;
            a  = b;
            b  = t;
            t  = da;
            da = db;
            db = t;
        end
        ca = climb_up((blae_pkg::NODE_W+1)'(a + 1), da - db);
        cb = (blae_pkg::NODE_W+1)'(b + 1);
        if (ca == 0)
            return '0;
        if (ca == cb)
            return ca;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            ua = lift_tbl[int'(ca) - 1][i];
            ub = lift_tbl[int'(cb) - 1][i];
            if (ua != ub)
            begin
                if (ua == 0 || ub == 0)
                    return '0;
                ca = ua;
                cb = ub;
            end
        end
        return lift_tbl[int'(ca) - 1][0];
    endfunction

    // write one node's jump row and depth from its parent
    function automatic void record_node(int node, int parent, bit has_parent);
        bit [blae_pkg::NODE_W:0] mid;
        int            d;
        d = 0;
        if (has_parent)
        begin
            d = int'(depth_tbl[parent]) + 1;
            if (d > DEPTH_CAP)
                d = DEPTH_CAP;
        end
        lift_tbl[node][0] = has_parent ? (blae_pkg::NODE_W+1)'(parent + 1) : '0;
        for (int i = 1; i < LEVELS; i++)
        begin
            mid = lift_tbl[node][i-1];
            lift_tbl[node][i] = (mid == 0) ? '0 : lift_tbl[int'(mid) - 1][i-1];
        end
        depth_tbl[node] = blae_pkg::DEPTH_W'(d);
    endfunction

    function automatic answer_t to_answer(bit [blae_pkg::NODE_W:0] code);
        answer_t a;
        a.found = (code != 0);
        a.node  = (code == 0) ? '0 : blae_pkg::NODE_W'(code - 1);
        return a;
    endfunction

    // queue one request word; an add marks its node as written
    task automatic queue_word(logic [blae_pkg::CMD_W-1:0] cmd, int node, int other, int hp,
                              int gens);
        req_word_t w;
        w.command    = cmd;
        w.node_id    = blae_pkg::NODE_W'(node);
        w.other_node = blae_pkg::NODE_W'(other);
        w.has_parent = (hp != 0);
        w.distance   = blae_pkg::DIST_W'(gens);
        words_to_send.insert(words_to_send.size(), w);
        if (cmd == blae_pkg::CMD_ADD && !added[node])
        begin
            added[node] = 1'b1;
            known.insert(known.size(), node);
        end
    endtask

    function automatic int any_known();
        return known[$urandom_range(0, known.size() - 1)];
    endfunction

    function automatic int recent_known();
        int span;
        span = known.size() < 6 ? known.size() : 6;
        return known[known.size() - 1 - $urandom_range(0, span - 1)];
    endfunction

    // driver: next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin : driver
        req_word_t w;
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req_fired)
        begin
            if (words_to_send.size() > 0 && (quiet || $urandom_range(0, 99) >= 10))
            begin
                w = words_to_send.pop_front();
                req.valid      <= 1'b1;
                req.command    <= w.command;
                req.node_id    <= w.node_id;
                req.other_node <= w.other_node;
                req.has_parent <= w.has_parent;
                req.distance   <= w.distance;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (!hold_done && cycle_count >= 3000)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= quiet || ($urandom_range(0, 99) >= 10);
    end

    // monitor: check result words, then predict from the accepted word
    always @(posedge clk)
    begin : monitor
        answer_t want;
        cycle_count = cycle_count + 1;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0t: unexpected result word: expected none, actual node %0d found %0b",
                             $time, rsp.result_node, rsp.result_valid);
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.result_valid !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: result_valid mismatch: expected %0b, actual %0b",
                                 $time, want.found, rsp.result_valid);
                end
                if (rsp.result_node !== want.node)
                begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: result_node mismatch: expected %0d, actual %0d",
                                 $time, want.node, rsp.result_node);
                end
            end
        end
        req_fired = rst_n && req.valid && req.ready;
        if (req_fired)
        begin
            case (req.command)
                blae_pkg::CMD_ADD:
                    record_node(req.node_id, req.other_node, req.has_parent);
                blae_pkg::CMD_LCA:
                    answers_due.insert(answers_due.size(),
                                       to_answer(common_ancestor(req.node_id,
                                                                 req.other_node)));
                blae_pkg::CMD_KTH:
                    answers_due.insert(answers_due.size(),
                                       to_answer(climb_up({1'b0, req.node_id} + 1'b1,
                                                          req.distance)));
                default:
                    ;
            endcase
        end
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int order [0:NODES-1];
        int i;
        int j;
        int t;
        int r;
        int a;
        int node;

        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.command    = blae_pkg::CMD_ADD;
        req.node_id    = '0;
        req.other_node = '0;
        req.has_parent = 1'b0;
        req.distance   = '0;
        rsp.ready      = 1'b0;

        // directed: small tree 0-1023-512-341-682, side branch 5, separate root 1000
        queue_word(blae_pkg::CMD_ADD, 0, 1023, 0, 0);
        queue_word(blae_pkg::CMD_ADD, 1023, 0, 1, 1023);
        queue_word(blae_pkg::CMD_ADD, 512, 1023, 1, 0);
        queue_word(blae_pkg::CMD_ADD, 341, 512, 1, 0);
        queue_word(blae_pkg::CMD_ADD, 682, 341, 1, 0);
        queue_word(blae_pkg::CMD_ADD, 5, 1023, 1, 0);
        queue_word(blae_pkg::CMD_ADD, 1000, 682, 0, 0);
        // distance zero, exact root, one past the depth, all bits set
        queue_word(blae_pkg::CMD_KTH, 682, 0, 0, 0);
        queue_word(blae_pkg::CMD_KTH, 682, 0, 0, 4);
        queue_word(blae_pkg::CMD_KTH, 682, 0, 0, 5);
        queue_word(blae_pkg::CMD_KTH, 682, 1023, 1, 1023);
        queue_word(blae_pkg::CMD_KTH, 0, 0, 0, 0);
        // lca both orders, ancestor case, same node, different trees
        queue_word(blae_pkg::CMD_LCA, 682, 5, 0, 0);
        queue_word(blae_pkg::CMD_LCA, 5, 682, 0, 0);
        queue_word(blae_pkg::CMD_LCA, 682, 512, 0, 0);
        queue_word(blae_pkg::CMD_LCA, 0, 0, 0, 0);
        queue_word(blae_pkg::CMD_LCA, 682, 1000, 0, 0);
        queue_word(blae_pkg::CMD_LCA, 1023, 682, 1, 1023);
        // unused command with every field high
        queue_word(CMD_NOP, 1023, 1023, 1, 1023);
        // node as its own parent, then climbs and a broken joint jump
        queue_word(blae_pkg::CMD_ADD, 1000, 1000, 1, 0);
        queue_word(blae_pkg::CMD_KTH, 1000, 0, 0, 3);
        queue_word(blae_pkg::CMD_LCA, 1000, 682, 0, 0);

        // random forests growing mostly from recent nodes
        for (i = 0; i < 200; i++)
        begin
            r = $urandom_range(0, 99);
            if (known.size() < 3 || r < 40)
            begin
                node = $urandom_range(0, NODES - 1);
                if ($urandom_range(0, 9) == 0)
                    queue_word(blae_pkg::CMD_ADD, node, $urandom_range(0, 1023), 0,
                               $urandom_range(0, 1023));
                else
                    queue_word(blae_pkg::CMD_ADD, node,
                               ($urandom_range(0, 9) < 7) ? recent_known() : any_known(),
                               1, $urandom_range(0, 1023));
            end
            else if (r < 68)
            begin
                a = any_known();
                queue_word(blae_pkg::CMD_LCA, a,
                           ($urandom_range(0, 4) == 0) ? a : any_known(),
                           $urandom_range(0, 1), $urandom_range(0, 1023));
            end
            else if (r < 96)
                queue_word(blae_pkg::CMD_KTH, any_known(), $urandom_range(0, 1023),
                           $urandom_range(0, 1),
                           ($urandom_range(0, 9) < 6) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, 1023));
            else
                queue_word(CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1), $urandom_range(0, 1023));
        end

        // one chain through every node in shuffled order, deep enough to saturate
        for (i = 0; i < NODES; i++)
            order[i] = i;
        for (i = NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        queue_word(blae_pkg::CMD_ADD, order[0], $urandom_range(0, 1023), 0, 0);
        for (i = 1; i < NODES; i++)
        begin
            queue_word(blae_pkg::CMD_ADD, order[i], order[i-1], 1, $urandom_range(0, 1023));
            if (i % 6 == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_word(blae_pkg::CMD_KTH, order[$urandom_range(i / 2, i)], 0, 0,
                               $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, i));
                else
                    queue_word(blae_pkg::CMD_LCA, order[$urandom_range(0, i)],
                               order[$urandom_range(0, i)], 0, 0);
            end
        end
        // re-parent the tip to itself: depth stays clamped at the cap
        for (i = 0; i < 3; i++)
            queue_word(blae_pkg::CMD_ADD, order[NODES-1], order[NODES-1], 1, 0);
        queue_word(blae_pkg::CMD_KTH, order[NODES-1], 0, 0, 1023);
        queue_word(blae_pkg::CMD_KTH, order[NODES-2], 0, 0, 1022);
        queue_word(blae_pkg::CMD_LCA, order[NODES-1], order[500], 0, 0);
        queue_word(blae_pkg::CMD_LCA, order[NODES-2], order[3], 0, 0);

        // every node now written: fully random words, cycles allowed
        for (i = 0; i < 150; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                queue_word(blae_pkg::CMD_ADD, $urandom_range(0, 1023),
                           $urandom_range(0, 1023),
                           $urandom_range(0, 9) != 0, $urandom_range(0, 1023));
            else if (r < 65)
                queue_word(blae_pkg::CMD_LCA, $urandom_range(0, 1023),
                           $urandom_range(0, 1023),
                           $urandom_range(0, 1), $urandom_range(0, 1023));
            else if (r < 97)
                queue_word(blae_pkg::CMD_KTH, $urandom_range(0, 1023),
                           $urandom_range(0, 1023),
                           $urandom_range(0, 1), $urandom_range(0, 1023));
            else
                queue_word(CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1), $urandom_range(0, 1023));
        end

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: all words taken, all answers back, then the tail
        while (words_to_send.size() != 0 || req.valid)
            @(negedge clk);
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        if (mismatches == 0 && answers_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/blae_pkg.sv
rtl/core/blae_req_if.sv
rtl/core/blae_rsp_if.sv
rtl/core/binary_lifting_ancestor_engine_top.sv
verif/binary_lifting_ancestor_engine_top_test.sv
